// File: rtl/sha_pkg.sv
package sha_pkg;

  typedef logic [31:0] word_t;

  // controller -> datapath commands
  typedef struct packed {
    logic       restart;    // load initial values, clear counters
    logic       put;        // write put_data into buffer at fill count
    logic [7:0] put_data;
    logic       count_msg;  // bump message byte count
    logic       comp_start; // load round vars and schedule from buffer
    logic       round_en;   // run one round
    logic       comp_done;  // add round vars into chain state
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0]  fill;
    logic [63:0] bits;
  } sha_stat_t;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t init_value(logic mode, logic [2:0] i);
    word_t v;
    v = '0;
    if (!mode) begin
      case (i)
        3'd0: v = 32'h6a09e667;
        3'd1: v = 32'hbb67ae85;
        3'd2: v = 32'h3c6ef372;
        3'd3: v = 32'ha54ff53a;
        3'd4: v = 32'h510e527f;
        3'd5: v = 32'h9b05688c;
        3'd6: v = 32'h1f83d9ab;
        default: v = 32'h5be0cd19;
      endcase
    end else begin
      case (i)
        3'd0: v = 32'hc1059ed8;
        3'd1: v = 32'h367cd507;
        3'd2: v = 32'h3070dd17;
        3'd3: v = 32'hf70e5939;
        3'd4: v = 32'hffc00b31;
        3'd5: v = 32'h68581511;
        3'd6: v = 32'h64f98fa7;
        default: v = 32'hbefa4fa4;
      endcase
    end
    return v;
  endfunction

  function automatic word_t round_k(logic [5:0] i);
    word_t k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

endpackage

// File: rtl/sha_datapath.sv
module sha_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic             mode,
  input  sha_pkg::sha_cmd_t cmd,
  input  logic [5:0]       round,
  input  logic [2:0]       rd_index,
  output sha_pkg::sha_stat_t stat,
  output sha_pkg::word_t   rd_word
);
  import sha_pkg::*;

  word_t       chain [8];
  word_t       v [8];
  word_t       w [16];
  word_t       blk [16];   // block buffer, big-endian byte lanes
  logic [5:0]  fill;
  logic [60:0] msg_count;

  word_t sched, wt, t1, t2, s0, s1;

  always_comb begin
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    sched = s1 + w[9] + s0 + w[0];
    wt = (round < 6'd16) ? w[0] : sched;
    t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
      + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(round) + wt;
    t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
      + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  assign stat.fill = fill;
  assign stat.bits = {msg_count, 3'b000};
  assign rd_word = chain[rd_index];

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      fill <= '0;
      msg_count <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= init_value(mode, 3'(i));
    end else begin
      if (cmd.put) begin
        blk[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= cmd.put_data;
        fill <= fill + 6'd1;
      end
      if (cmd.count_msg) msg_count <= msg_count + 61'd1;
      if (cmd.comp_done)
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
    end
    if (cmd.comp_start) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
      for (int i = 0; i < 16; i++) w[i] <= blk[i];
    end else if (cmd.round_en) begin
      // shift window: w[0] is the word of rounds 0 to 15; later rounds use sched
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wt;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end
  end
endmodule

// File: rtl/sha_control.sv
module sha_control (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic [7:0]        msg_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  sha_pkg::sha_stat_t stat,
  output sha_pkg::sha_cmd_t cmd,
  output logic [5:0]        round,
  output logic [2:0]        rd_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              last_word
);
  import sha_pkg::*;

  typedef enum logic [2:0] {IDLE, COMP_LD, COMP_RUN, COMP_ADD, PAD, EMIT} state_t;

  state_t     state;
  logic       padding;   // compression belongs to finish sequence
  logic [63:0] bits;
  logic [2:0] len_idx;   // length byte position during padding
  logic       len_phase;
  logic       bits_done;

  assign in_ready  = (state == IDLE) && !cfg_valid && !rst;
  assign cfg_ready = (state == IDLE) && !rst;
  assign out_valid = (state == EMIT);
  assign last_word = (rd_index == 3'd7);

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: begin
        if (cfg_valid) cmd.restart = 1'b1;
        else if (in_valid) begin
          cmd.put = 1'b1;
          cmd.put_data = func ? PadByte : msg_byte;
          cmd.count_msg = !func;
        end
      end
      COMP_LD:  cmd.comp_start = 1'b1;
      COMP_RUN: cmd.round_en = 1'b1;
      COMP_ADD: cmd.comp_done = 1'b1;
      PAD: begin
        cmd.put = 1'b1;
        cmd.put_data = len_phase ? bits[63 - 8*len_idx -: 8] : 8'h00;
      end
      EMIT: cmd.restart = out_ready && (rd_index == 3'd7);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      padding <= 1'b0;
      round <= '0;
      rd_index <= '0;
      len_idx <= '0;
      len_phase <= 1'b0;
      bits_done <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (!cfg_valid && in_valid) begin
            bits <= stat.bits;
            padding <= func;
            // pad byte at offset 55: length bytes follow at once
            len_phase <= func && (stat.fill == 6'd55);
            len_idx <= '0;
            if (stat.fill == 6'd63) state <= COMP_LD;
            else if (func) state <= PAD;
          end
        end
        COMP_LD: begin
          round <= '0;
          state <= COMP_RUN;
        end
        COMP_RUN: begin
          round <= round + 6'd1;
          if (round == 6'd63) state <= COMP_ADD;
        end
        COMP_ADD: begin
          if (!padding) state <= IDLE;
          else if (len_phase && len_idx == 3'd0 && stat.fill == 6'd0 &&
                   bits_done) begin
            rd_index <= '0;
            state <= EMIT;
          end else state <= PAD;
        end
        PAD: begin
          if (len_phase) begin
            len_idx <= len_idx + 3'd1;
            if (len_idx == 3'd7) bits_done <= 1'b1;
          end else if (stat.fill == 6'd55) begin
            len_phase <= 1'b1;
          end
          if (stat.fill == 6'd63) state <= COMP_LD;
        end
        EMIT: begin
          if (out_ready) begin
            rd_index <= rd_index + 3'd1;
            if (rd_index == 3'd7) state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if (state == IDLE) bits_done <= 1'b0;
    end
  end
endmodule

// File: rtl/sha256_hash_engine_unit.sv
// Streaming SHA-256/SHA-224 engine, one byte per input word.
// Byte words are taken only while idle; the 64th byte of a block starts
// the compression (one round per cycle in the shared round unit).
// Finish pads byte by byte, runs one or two compressions,
// then presents eight digest words, one per accepted output cycle.
// Synchronous active-high rst loads SHA-256 initial values, clears counters.
module sha256_hash_engine_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  msg_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        digest_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha_pkg::*;

  logic      mode, mode_sel;
  sha_cmd_t  cmd;
  sha_stat_t stat;
  logic [5:0] round;
  logic [2:0] rd_index;

  // mode register; a write restarts with the new mode's initial values
  always_ff @(posedge clk) begin
    if (rst) mode <= 1'b0;
    else if (cfg_valid && cfg_ready) mode <= digest_mode;
  end
  // reset always loads the SHA-256 values
  assign mode_sel = rst ? 1'b0 : ((cfg_valid && cfg_ready) ? digest_mode : mode);

  sha_control u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .func, .msg_byte,
    .cfg_valid, .cfg_ready, .stat, .cmd, .round, .rd_index,
    .out_valid, .out_ready, .last_word
  );

  sha_datapath u_dp (
    .clk, .rst, .mode(mode_sel), .cmd, .round, .rd_index, .stat,
    .rd_word(digest_word)
  );

  assign word_index = rd_index;
endmodule
